/* rtl/ftws_pkg.sv */
// ----------------------------------------------------------------------------
// ftws_pkg: shared constants for the frame time window statistics block
// Window depth, field widths and the fixed constants of the statistics.
// ----------------------------------------------------------------------------
package ftws_pkg;

    // window depth, 2 to 127
    localparam int WINDOW_DEPTH = 64;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

    // field widths
    localparam int DUR_W   = 22;
    localparam int VALID_W = 7;
    localparam int RATE_W  = 28;
    localparam int SUM_W   = DUR_W + CNT_W;

    // shared divider operand widths
    localparam int DIV_NUM_W = (SUM_W > RATE_W) ? SUM_W : RATE_W;
    localparam int DIV_DEN_W = DUR_W;

    // fixed constants
    localparam logic [DUR_W-1:0]  LEAST_LIMIT    = DUR_W'(999000);
    localparam logic [RATE_W-1:0] RATE_NUMERATOR = RATE_W'(256000000);

endpackage

/* rtl/ftws_ram.sv */
// ----------------------------------------------------------------------------
// ftws_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ftws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ftws_div.sv */
// ----------------------------------------------------------------------------
// ftws_div: shared restoring divider
// One quotient bit per cycle; operands latched on start, done pulses once.
// ----------------------------------------------------------------------------
module ftws_div
    import ftws_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quo
);

    localparam int STEP_W = $clog2(DIV_NUM_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_step;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] r_quo;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;
    logic [DIV_DEN_W-1:0] n_rem;

    // trial subtract of the shifted remainder
    always_comb begin
        trial = {r_rem, r_quo[DIV_NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        fits  = (trial >= {1'b0, r_den});
        n_rem = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    end

    // iteration control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_NUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* rtl/frame_time_window_stats.sv */
// Each item is handled in turn: a one-entry-per-cycle scan of the history RAM,
// then two 1-bit-per-cycle divisions (mean, frame rate) on the one shared
// divider. No new input word is taken until the result word is loaded, and a
// result still held on the output delays the next load.
// Reset clears the valid bit of every history slot at once, so no clearing pass.
// ----------------------------------------------------------------------------
// frame_time_window_stats: sliding-window frame time statistics
// Stores each frame duration in a ring, then gives mean, min, max, count and
// the Q8 frame rate of the current frame.
// ----------------------------------------------------------------------------
module frame_time_window_stats
    import ftws_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [DUR_W-1:0]   i_frame_time_us,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [DUR_W-1:0]   o_current_us,
    output logic [DUR_W-1:0]   o_mean_us,
    output logic [DUR_W-1:0]   o_least_us,
    output logic [DUR_W-1:0]   o_greatest_us,
    output logic [VALID_W-1:0] o_valid_entries,
    output logic [RATE_W-1:0]  o_rate_q8
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_RATE_GO,
        S_RATE_WAIT,
        S_DONE
    } t_state;

    t_state r_state;

    logic [PTR_W-1:0]        r_wr_pos;
    logic [WINDOW_DEPTH-1:0] r_vbits;
    logic [PTR_W-1:0]        r_rd_addr;
    logic                    r_pend;
    logic [PTR_W-1:0]        r_pend_slot;

    logic [DUR_W-1:0]  r_dur;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_count;
    logic [DUR_W-1:0]  r_least;
    logic [DUR_W-1:0]  r_greatest;
    logic [DUR_W-1:0]  r_mean;
    logic [RATE_W-1:0] r_rate;

    logic               accept;
    logic [DUR_W-1:0]   ram_q;
    logic [DUR_W-1:0]   entry;
    logic               div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic               div_done;
    logic [DIV_NUM_W-1:0] div_quo;
    logic               out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !o_out_valid || i_out_ready;

    // history ring
    ftws_ram #(
        .WIDTH (DUR_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_wr_pos),
        .i_wdata (i_frame_time_us),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_q)
    );

    // slot never written since reset reads as empty
    assign entry = r_vbits[r_pend_slot] ? ram_q : '0;

    // divider operand select
    always_comb begin
        div_start = (r_state == S_MEAN_GO) || (r_state == S_RATE_GO);
        if (r_state == S_RATE_GO) begin
            div_num = DIV_NUM_W'(RATE_NUMERATOR);
            div_den = DIV_DEN_W'(r_dur);
        end else begin
            div_num = DIV_NUM_W'(r_sum);
            div_den = DIV_DEN_W'(r_count);
        end
    end

    ftws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // sequencer, ring pointer, valid bits and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_pos    <= '0;
            r_vbits     <= '0;
            r_pend      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            // output word valid: set on load, cleared once taken
            if (r_state == S_DONE && out_free) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            // read data of a scan address arrives in the next cycle
            r_pend <= (r_state == S_SCAN);
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_vbits[r_wr_pos] <= 1'b1;
                        r_wr_pos <= (r_wr_pos == PTR_W'(WINDOW_DEPTH - 1)) ?
                                    '0 : r_wr_pos + 1'b1;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_rd_addr == PTR_W'(WINDOW_DEPTH - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN:     r_state <= S_MEAN_GO;
                S_MEAN_GO:   r_state <= S_MEAN_WAIT;
                S_MEAN_WAIT: begin
                    if (div_done) begin
                        r_state <= S_RATE_GO;
                    end
                end
                S_RATE_GO:   r_state <= S_RATE_WAIT;
                S_RATE_WAIT: begin
                    if (div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default:     r_state <= S_IDLE;
            endcase
        end
    end

    // scan address and statistics accumulation
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dur      <= i_frame_time_us;
            r_rd_addr  <= '0;
            r_sum      <= '0;
            r_count    <= '0;
            r_least    <= LEAST_LIMIT;
            r_greatest <= '0;
        end else begin
            if (r_state == S_SCAN) begin
                r_pend_slot <= r_rd_addr;
                r_rd_addr   <= r_rd_addr + 1'b1;
            end
            if (r_pend && (entry != '0)) begin
                r_sum   <= r_sum + SUM_W'(entry);
                r_count <= r_count + 1'b1;
                if (entry < r_least) begin
                    r_least <= entry;
                end
                if (entry > r_greatest) begin
                    r_greatest <= entry;
                end
            end
        end
        // quotients; a zero divisor forces zero
        if (r_state == S_MEAN_WAIT && div_done) begin
            r_mean <= (r_count == '0) ? '0 : div_quo[DUR_W-1:0];
        end
        if (r_state == S_RATE_WAIT && div_done) begin
            r_rate <= (r_dur == '0) ? '0 : div_quo[RATE_W-1:0];
        end
        // output word load
        if (r_state == S_DONE && out_free) begin
            o_current_us    <= r_dur;
            o_mean_us       <= r_mean;
            o_least_us      <= (r_least >= LEAST_LIMIT) ? '0 : r_least;
            o_greatest_us   <= r_greatest;
            o_valid_entries <= VALID_W'(r_count);
            o_rate_q8       <= r_rate;
        end
    end

endmodule

/* bench/ftws_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ftws_checker: scoreboard for the frame time window statistics block
// Watches both channels. Every accepted duration updates a private copy of
// the history ring and queues the statistics it should produce. Every
// accepted result word is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module ftws_checker
    import ftws_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [DUR_W-1:0]   i_frame_time_us,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [DUR_W-1:0]   i_current_us,
    input  logic [DUR_W-1:0]   i_mean_us,
    input  logic [DUR_W-1:0]   i_least_us,
    input  logic [DUR_W-1:0]   i_greatest_us,
    input  logic [VALID_W-1:0] i_valid_entries,
    input  logic [RATE_W-1:0]  i_rate_q8,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    typedef struct packed {
        logic [DUR_W-1:0]   current_us;
        logic [DUR_W-1:0]   mean_us;
        logic [DUR_W-1:0]   least_us;
        logic [DUR_W-1:0]   greatest_us;
        logic [VALID_W-1:0] valid_entries;
        logic [RATE_W-1:0]  rate_q8;
    } t_frame_stats;

    // private copy of the ring, zero marks an empty slot
    logic [DUR_W-1:0] ring [WINDOW_DEPTH];
    logic [PTR_W-1:0] ring_wr;
    t_frame_stats     stats_q[$];
    int               mismatches = 0;
    int               results_seen = 0;

    // store one duration, then rescan the ring for the statistics
    function automatic t_frame_stats record_frame(input logic [DUR_W-1:0] dur);
        t_frame_stats     s;
        logic [SUM_W-1:0] total;
        logic [CNT_W-1:0] filled;
        logic [DUR_W-1:0] lo;
        logic [DUR_W-1:0] hi;
        ring[ring_wr] = dur;
        ring_wr = (ring_wr == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ring_wr + 1'b1;
        total  = '0;
        filled = '0;
        lo     = LEAST_LIMIT;
        hi     = '0;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            if (ring[i] != '0) begin
                total  = total + SUM_W'(ring[i]);
                filled = filled + 1'b1;
                if (ring[i] < lo)
                    lo = ring[i];
                if (ring[i] > hi)
                    hi = ring[i];
            end
        end
        // no entry under the limit reads as zero
        if (lo >= LEAST_LIMIT)
            lo = '0;
        s.current_us    = dur;
        s.mean_us       = (filled != '0) ? DUR_W'(total / filled) : '0;
        s.least_us      = lo;
        s.greatest_us   = hi;
        s.valid_entries = VALID_W'(filled);
        s.rate_q8       = (dur != '0) ? RATE_W'(RATE_NUMERATOR / dur) : '0;
        return s;
    endfunction

    task automatic check_field(input string name, input logic [RATE_W-1:0] want,
                               input logic [RATE_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t ns: result %0d, %s expected %0d, got %0d",
                         $realtime, results_seen, name, want, got);
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge i_clk) begin : watch
        t_frame_stats want;
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_DEPTH; i++)
                ring[i] = '0;
            ring_wr = '0;
            stats_q.delete();
        end else begin
            // result word first: it belongs to an earlier duration
            if (i_out_valid && i_out_ready) begin
                if (stats_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t ns: result word with nothing outstanding", $realtime);
                end else begin
                    want = stats_q.pop_front();
                    check_field("current_us", RATE_W'(want.current_us),
                                RATE_W'(i_current_us));
                    check_field("mean_us", RATE_W'(want.mean_us), RATE_W'(i_mean_us));
                    check_field("least_us", RATE_W'(want.least_us), RATE_W'(i_least_us));
                    check_field("greatest_us", RATE_W'(want.greatest_us),
                                RATE_W'(i_greatest_us));
                    check_field("valid_entries", RATE_W'(want.valid_entries),
                                RATE_W'(i_valid_entries));
                    check_field("rate_q8", want.rate_q8, i_rate_q8);
                end
                results_seen++;
            end
            if (i_in_valid && i_in_ready)
                stats_q.push_back(record_frame(i_frame_time_us));
        end
        o_pending    <= stats_q.size();
        o_fail_count <= mismatches;
        o_checked    <= results_seen;
    end

endmodule

/* bench/tb_frame_time_window_stats.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_time_window_stats: bench for the frame time window statistics
// Drives directed and random frame durations through the block under four
// flow-control regimes, with a checker alongside that predicts and compares.
// ----------------------------------------------------------------------------
module tb_frame_time_window_stats;
    import ftws_pkg::*;

    localparam int WORDS_PER_PHASE = 300;
    localparam int TAIL_CYCLES     = WINDOW_DEPTH + 2 * DIV_NUM_W + 16;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [DUR_W-1:0]   frame_time_us = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [DUR_W-1:0]   current_us;
    logic [DUR_W-1:0]   mean_us;
    logic [DUR_W-1:0]   least_us;
    logic [DUR_W-1:0]   greatest_us;
    logic [VALID_W-1:0] valid_entries;
    logic [RATE_W-1:0]  rate_q8;

    int fail_count;
    int pending;
    int checked;
    int idle_pct = 0;
    int stall_pct = 0;
    int words_sent = 0;

    logic [DUR_W-1:0] directed_durs[] = '{
        22'd0, 22'd4194303, 22'd999000, 22'd999001, 22'd998999, 22'd1, 22'd0,
        22'd3, 22'd2097152, 22'd1000000, 22'd16667, 22'd16666, 22'd33333,
        22'd256, 22'd4194302, 22'd999, 22'd7, 22'd0, 22'd1398101, 22'd2796202
    };

    always #2 clk = ~clk;

    frame_time_window_stats DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_frame_time_us (frame_time_us),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_current_us    (current_us),
        .o_mean_us       (mean_us),
        .o_least_us      (least_us),
        .o_greatest_us   (greatest_us),
        .o_valid_entries (valid_entries),
        .o_rate_q8       (rate_q8)
    );

    ftws_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_frame_time_us (frame_time_us),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_current_us    (current_us),
        .i_mean_us       (mean_us),
        .i_least_us      (least_us),
        .i_greatest_us   (greatest_us),
        .i_valid_entries (valid_entries),
        .i_rate_q8       (rate_q8),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    // result side back-pressure
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // present one word from a falling edge and hold it until taken
    task automatic send_word(input logic [DUR_W-1:0] dur);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        frame_time_us <= dur;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        @(negedge clk);
    endtask

    // plausible times most often, also zeros, long stalls, full-range noise
    function automatic logic [DUR_W-1:0] pick_duration();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10)
            return '0;
        else if (sel < 55)
            return DUR_W'($urandom_range(100000, 4000));
        else if (sel < 70)
            return DUR_W'($urandom);
        else if (sel < 85)
            return DUR_W'($urandom_range(4194303, 999000));
        else if (sel < 95)
            return DUR_W'($urandom_range(999, 1));
        else
            return DUR_W'($urandom_range(999010, 998990));
    endfunction

    task automatic drain_results();
        while (pending != 0)
            @(negedge clk);
    endtask

    // stimulus
    initial begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty window, long-only window, limits and rate edges
        foreach (directed_durs[i])
            send_word(directed_durs[i]);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 61; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            // hold the sender until the block has emptied
            if (phase == 2) begin
                in_valid <= 1'b0;
                drain_results();
            end
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                // a run of zeros empties the ring, then long frames only
                if (phase == 1 && n >= 100 && n < 100 + WINDOW_DEPTH)
                    send_word('0);
                else if (phase == 1 && n >= 100 + WINDOW_DEPTH && n < 170 + WINDOW_DEPTH)
                    send_word(DUR_W'($urandom_range(4194303, 999000)));
                else
                    send_word(pick_duration());
            end
        end
        in_valid <= 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Sent %0d frame durations and checked %0d statistic words,", words_sent,
                 checked);
        $display("covering empty, long-only and wrapped windows under four stall regimes.");
        if (fail_count == 0 && pending == 0)
            $display("tb_frame_time_window_stats: PASS");
        else
            $display("tb_frame_time_window_stats: FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("Timed out with %0d results outstanding.", pending);
        $display("tb_frame_time_window_stats: FAIL");
        $finish;
    end

endmodule
